### hw/rtl/lru_key_value_cache_unit_macros.svh
// Assertion macros shared by the cache RTL modules.
// Included by the controller and the datapath; depends on nothing else.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define LKVC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkvc assertion failed");
// Next-cycle implication, disabled during reset.
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/lkvc_pkg.sv
// Shared constants and controller/datapath interface types for the LRU cache.
// Used by lkvc_ctrl, lkvc_datapath and the top level; depends on nothing.
package lkvc_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 16;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CSR_W = 5;
   localparam logic [CSR_W-1:0] CSR_RESET = 5'd16;

   // Request kinds.
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the incoming request
      logic lookup;    // compare keys and register the search results
      logic update;    // apply the request to the store
      logic load_out;  // move the result into the response register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;  // response register can take a new result this cycle
   } dp_status_type;

endpackage

### hw/rtl/lkvc_ctrl.sv
// Sequencing state machine for the LRU cache.
// Depends on lkvc_pkg and the assertion macro header.
`include "lru_key_value_cache_unit_macros.svh"
module lkvc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output lkvc_pkg::ctrl_cmd_type cmd,
   input  lkvc_pkg::dp_status_type status
);
   import lkvc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_MATCH, ST_UPDATE, ST_FINISH} state_type;

   state_type state_ff;
   logic      req_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_MATCH;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_MATCH:  state_ff <= ST_UPDATE;
            ST_UPDATE: state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (status.out_free) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;

   always_comb begin
      cmd.capture  = req_valid && req_ready_ff;
      cmd.lookup   = (state_ff == ST_MATCH);
      cmd.update   = (state_ff == ST_UPDATE);
      cmd.load_out = (state_ff == ST_FINISH) && status.out_free;
   end

   // Ready is only raised once a result has left for the response register.
   `LKVC_ASSERT_NEXT(a_finish_exit, clock, reset, cmd.load_out, state_ff == ST_IDLE && req_ready)
   // A request is taken only with the sequencer idle.
   `LKVC_ASSERT_IMPLIES(a_capture_idle, clock, reset, cmd.capture, state_ff == ST_IDLE)
   // Once a request is taken, no other is accepted until its result is on its way.
   `LKVC_ASSERT_NEXT(a_capture_busy, clock, reset, cmd.capture, !req_ready)

endmodule

### hw/rtl/lkvc_datapath.sv
// Key store, recency ranks, value memory and response register of the LRU cache.
// Depends on lkvc_pkg and the assertion macro header.
`include "lru_key_value_cache_unit_macros.svh"
module lkvc_datapath #(
   parameter int MAX_ENTRIES = lkvc_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lkvc_pkg::ctrl_cmd_type        cmd,
   output lkvc_pkg::dp_status_type       status,
   input  logic                          req_type,
   input  logic [lkvc_pkg::KEY_W-1:0]    req_lookup_key,
   input  logic [lkvc_pkg::VAL_W-1:0]    req_write_value,
   input  logic                          csr_wr_en,
   input  logic [lkvc_pkg::CSR_W-1:0]    csr_wr_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [lkvc_pkg::VAL_W-1:0]    rsp_read_value,
   output logic                          rsp_evicted
);
   import lkvc_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);        // slot index and rank width
   localparam int CW = $clog2(MAX_ENTRIES + 1);    // fill count width
   localparam int LW = (CW > CSR_W) ? CW : CSR_W;  // common width for the limit compare

   // Configuration.
   logic [CSR_W-1:0] csr_ff;

   // Latched request.
   logic             put_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] wval_ff;

   // Store.
   logic [KEY_W-1:0] entry_key_ff [MAX_ENTRIES];
   logic [VAL_W-1:0] entry_value_mem [MAX_ENTRIES];
   logic             valid_ff [MAX_ENTRIES];
   logic [IW-1:0]    rank_ff [MAX_ENTRIES];
   logic [IW-1:0]    rank_in [MAX_ENTRIES];
   logic [CW-1:0]    filled_ff;

   // Search results.
   logic [MAX_ENTRIES-1:0] match_vec;
   logic [MAX_ENTRIES-1:0] victim_vec;
   logic [IW-1:0]          hit_idx, free_idx, victim_idx, hit_rank, oldest_rank;
   logic [LW-1:0]          limit;
   logic                   hit_ff, room_ff;
   logic [IW-1:0]          hit_idx_ff, free_idx_ff, victim_idx_ff, hit_rank_ff;

   // Update stage.
   logic          do_promote, do_fill;
   logic [IW-1:0] sel_idx, sel_rank, wr_idx;

   // Result.
   logic [VAL_W-1:0] rd_data_ff;
   logic             res_hit_ff, res_evict_ff, res_get_ff;
   logic             rsp_valid_ff, rsp_hit_ff, rsp_evicted_ff;
   logic [VAL_W-1:0] rsp_read_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else if (csr_wr_en) begin
         csr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         put_ff  <= req_type;
         key_ff  <= req_lookup_key;
         wval_ff <= req_write_value;
      end
   end

   // Effective capacity: zero acts as one, anything above the store size is clamped.
   always_comb begin
      if (csr_ff == '0) begin
         limit = LW'(1);
      end else if (LW'(csr_ff) > LW'(MAX_ENTRIES)) begin
         limit = LW'(MAX_ENTRIES);
      end else begin
         limit = LW'(csr_ff);
      end
   end

   // Ranks of valid entries run from 0 to filled-1, so the oldest has rank filled-1.
   assign oldest_rank = IW'(filled_ff - CW'(1));

   always_comb begin
      hit_idx    = '0;
      free_idx   = '0;
      victim_idx = '0;
      hit_rank   = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_vec[i]  = valid_ff[i] && (entry_key_ff[i] == key_ff);
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == oldest_rank);
         if (match_vec[i]) begin
            hit_rank = hit_rank | rank_ff[i];
         end
      end
      // Scan downward so the lowest index wins.
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            hit_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
         if (victim_vec[i]) begin
            victim_idx = IW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff        <= |match_vec;
         room_ff       <= LW'(filled_ff) < limit;
         hit_idx_ff    <= hit_idx;
         free_idx_ff   <= free_idx;
         victim_idx_ff <= victim_idx;
         hit_rank_ff   <= hit_rank;
      end
   end

   assign do_promote = hit_ff || (put_ff && !room_ff);
   assign do_fill    = !hit_ff && put_ff && room_ff;
   assign sel_idx    = hit_ff ? hit_idx_ff : victim_idx_ff;
   assign sel_rank   = hit_ff ? hit_rank_ff : oldest_rank;
   assign wr_idx     = hit_ff ? hit_idx_ff : (room_ff ? free_idx_ff : victim_idx_ff);

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (do_promote) begin
            if (IW'(i) == sel_idx) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && rank_ff[i] < sel_rank) begin
               rank_in[i] = rank_ff[i] + IW'(1);
            end
         end else if (do_fill) begin
            if (IW'(i) == free_idx_ff) begin
               rank_in[i] = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + IW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
      end else if (cmd.update) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
         if (do_fill) begin
            valid_ff[free_idx_ff] <= 1'b1;
            filled_ff             <= filled_ff + CW'(1);
         end
      end
   end

   // Keys are written only on a put of an absent key.
   always_ff @(posedge clock) begin
      if (cmd.update && put_ff && !hit_ff) begin
         entry_key_ff[wr_idx] <= key_ff;
      end
   end

   // Value memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.update && put_ff) begin
         entry_value_mem[wr_idx] <= wval_ff;
      end
      if (cmd.update) begin
         rd_data_ff <= entry_value_mem[hit_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         res_hit_ff   <= hit_ff;
         res_evict_ff <= put_ff && !hit_ff && !room_ff;
         res_get_ff   <= (put_ff == REQ_GET);
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_hit_ff        <= res_hit_ff;
         rsp_evicted_ff    <= res_evict_ff;
         rsp_read_value_ff <= (res_hit_ff && res_get_ff) ? rd_data_ff : '0;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_read_value  = rsp_read_value_ff;

   // Valid keys are distinct, so a lookup matches at most one slot.
   `LKVC_ASSERT_IMPLIES(a_one_match, clock, reset, cmd.lookup, $onehot0(match_vec))
   // With any entry filled, exactly one valid entry holds the oldest rank.
   `LKVC_ASSERT_IMPLIES(a_one_oldest, clock, reset, cmd.lookup && filled_ff != '0, $onehot(victim_vec))
   // A fill adds exactly one entry.
   `LKVC_ASSERT_NEXT(a_fill_count, clock, reset, cmd.update && do_fill, filled_ff == $past(filled_ff) + CW'(1))

endmodule

### hw/rtl/lru_key_value_cache_unit.sv
// Fully associative key-value cache with least-recently-used replacement.
// Request channel (req_*): valid/ready; req_type selects get or put of a 32-bit key.
// Response channel (rsp_*): valid/ready; one response per request, in request order,
//   carrying hit, the value read on a get hit (zero otherwise) and an eviction flag.
// Configuration: csr_wr_en/csr_wr_data write the number of entries that may be filled
//   before eviction starts; write it only while no request is in flight.
// Each request passes in order through accept, parallel key compare against every slot,
//   store update with the value memory read, and transfer to the response register.
//   A new request is accepted only after the previous one has moved to the response
//   register, so requests are not overlapped.
// The response register holds a finished result while the receiver stalls; the next
//   request is still accepted and processed, and waits at its last step until the
//   response register frees.
// Reset (synchronous, active high) clears all valid marks, ranks and the fill count
//   and sets the capacity register to sixteen; no clearing pass is needed.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
module lru_key_value_cache_unit #(
   parameter int MAX_ENTRIES = lkvc_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_type,
   input  logic [lkvc_pkg::KEY_W-1:0] req_lookup_key,
   input  logic [lkvc_pkg::VAL_W-1:0] req_write_value,
   // Response channel.
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_hit,
   output logic [lkvc_pkg::VAL_W-1:0] rsp_read_value,
   output logic                       rsp_evicted,
   // Capacity register write port.
   input  logic                       csr_wr_en,
   input  logic [lkvc_pkg::CSR_W-1:0] csr_wr_data
);
   import lkvc_pkg::*;

   // Commands flow from the sequencer to the datapath; status flows back.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the key compare lanes, recency ranks, value memory and
   // the response register.
   lkvc_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_type),
      .req_lookup_key  (req_lookup_key),
      .req_write_value (req_write_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted)
   );

endmodule
